@@ rtl/vrc_pkg.sv @@
package vrc_pkg;

    // Table size and table precision
    localparam int EXP_TABLE_DEPTH = 64;
    localparam int FRACTION_BITS   = 16;

    localparam int EXP_W  = FRACTION_BITS + 1;
    localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int TAB_SH = 30 - FRACTION_BITS;

    // Conversion of a table value to Q1.16
    localparam int FB_DOWN = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
    localparam int FB_UP   = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
    localparam int FB_RND  = (1 << FB_DOWN) >> 1;

    // Shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [16:0] Q_ONE   = 17'd65536;
    localparam logic [16:0] SUM_MAX = 17'd131071;
    localparam logic [15:0] OUT_MAX = 16'hFFFF;

    // Table step r = exp(-h) in Q30 from a 20-term Taylor series
    localparam logic [63:0] SER_ONE = 64'd1 << 30;
    localparam logic [63:0] SER_H   = (64'd16 * SER_ONE) / 64'(EXP_TABLE_DEPTH);
    localparam logic [63:0] SER_T1  = (SER_ONE * SER_H) / (64'd1 * SER_ONE);
    localparam logic [63:0] SER_T2  = (SER_T1 * SER_H) / (64'd2 * SER_ONE);
    localparam logic [63:0] SER_T3  = (SER_T2 * SER_H) / (64'd3 * SER_ONE);
    localparam logic [63:0] SER_T4  = (SER_T3 * SER_H) / (64'd4 * SER_ONE);
    localparam logic [63:0] SER_T5  = (SER_T4 * SER_H) / (64'd5 * SER_ONE);
    localparam logic [63:0] SER_T6  = (SER_T5 * SER_H) / (64'd6 * SER_ONE);
    localparam logic [63:0] SER_T7  = (SER_T6 * SER_H) / (64'd7 * SER_ONE);
    localparam logic [63:0] SER_T8  = (SER_T7 * SER_H) / (64'd8 * SER_ONE);
    localparam logic [63:0] SER_T9  = (SER_T8 * SER_H) / (64'd9 * SER_ONE);
    localparam logic [63:0] SER_T10 = (SER_T9 * SER_H) / (64'd10 * SER_ONE);
    localparam logic [63:0] SER_T11 = (SER_T10 * SER_H) / (64'd11 * SER_ONE);
    localparam logic [63:0] SER_T12 = (SER_T11 * SER_H) / (64'd12 * SER_ONE);
    localparam logic [63:0] SER_T13 = (SER_T12 * SER_H) / (64'd13 * SER_ONE);
    localparam logic [63:0] SER_T14 = (SER_T13 * SER_H) / (64'd14 * SER_ONE);
    localparam logic [63:0] SER_T15 = (SER_T14 * SER_H) / (64'd15 * SER_ONE);
    localparam logic [63:0] SER_T16 = (SER_T15 * SER_H) / (64'd16 * SER_ONE);
    localparam logic [63:0] SER_T17 = (SER_T16 * SER_H) / (64'd17 * SER_ONE);
    localparam logic [63:0] SER_T18 = (SER_T17 * SER_H) / (64'd18 * SER_ONE);
    localparam logic [63:0] SER_T19 = (SER_T18 * SER_H) / (64'd19 * SER_ONE);

    localparam longint SER_ACC = longint'(SER_ONE)
        - longint'(SER_T1)  + longint'(SER_T2)  - longint'(SER_T3)  + longint'(SER_T4)
        - longint'(SER_T5)  + longint'(SER_T6)  - longint'(SER_T7)  + longint'(SER_T8)
        - longint'(SER_T9)  + longint'(SER_T10) - longint'(SER_T11) + longint'(SER_T12)
        - longint'(SER_T13) + longint'(SER_T14) - longint'(SER_T15) + longint'(SER_T16)
        - longint'(SER_T17) + longint'(SER_T18) - longint'(SER_T19);

    localparam logic [63:0] SER_R = (SER_ACC < 0) ? 64'd0 : 64'(SER_ACC);

    typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_TABLE_DEPTH];

    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } vrc_mul_req_t;

    // e[k] = exp(-16*k/DEPTH) in Q1.FRACTION_BITS, built as powers of the step r
    function automatic exp_tab_t build_exp_tab();
        logic [63:0]    e;
        exp_tab_t       tab;
        e = SER_ONE;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            if (k > 0) begin
                e = (e * SER_R + (64'd1 << 29)) >> 30;
            end
            tab[k] = EXP_W'((e + ((64'd1 << TAB_SH) >> 1)) >> TAB_SH);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

@@ rtl/volume_render_compositor.sv @@
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: density, distance, red, green, blue, ray_index;
//                                   s_tlast: last_sample
// m_*       out  m_tvalid/m_tready  m_tdata: pixel_ray, pixel_red, pixel_green, pixel_blue
//
// After acceptance, one sample request passes through 12 sequencer steps before the next
// s_tready; eight of them issue a product to the single 32x32 registered multiplier
// (x, table position, interpolation, weight, three colors, T).
// A finished pixel sits in the output register; new samples are taken meanwhile, and the
// final step waits only when a second pixel is due before the first is taken.
// Reset (aresetn low, synchronous) sets T to 1.0 and clears the sums and output valid.
module volume_render_compositor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // density, distance, red, green, blue, ray_index
    input  logic        s_tlast,   // last_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // pixel_ray, pixel_red, pixel_green, pixel_blue
);

    localparam int EW  = vrc_pkg::EXP_W;
    localparam int IW  = vrc_pkg::IDX_W;
    localparam int PW  = vrc_pkg::PROD_W;
    localparam int MW  = vrc_pkg::MUL_W;
    localparam int LW  = EW + 17;
    localparam int TIW = EW + vrc_pkg::FB_UP + 1;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_X    = 13'b0000000000010,
        ST_P    = 13'b0000000000100,
        ST_LERP = 13'b0000000001000,
        ST_FRAC = 13'b0000000010000,
        ST_TI   = 13'b0000000100000,
        ST_W    = 13'b0000001000000,
        ST_WR   = 13'b0000010000000,
        ST_R    = 13'b0000100000000,
        ST_G    = 13'b0001000000000,
        ST_B    = 13'b0010000000000,
        ST_T    = 13'b0100000000000,
        ST_UPD  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Captured sample
    logic [15:0] density_reg, distance_reg, red_reg, green_reg, blue_reg, ray_reg;
    logic        last_reg;

    // Working registers
    logic [EW-1:0] a_reg, a_next;
    logic [EW-1:0] diff_reg, diff_next;
    logic [15:0]   f_reg, f_next;
    logic          far_reg, far_next;
    logic [16:0]   ti_reg, ti_next;
    logic [16:0]   w_reg, w_next;

    // Ray state
    logic [16:0] t_reg, t_next;
    logic [16:0] sum_r_reg, sum_r_next;
    logic [16:0] sum_g_reg, sum_g_next;
    logic [16:0] sum_b_reg, sum_b_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;

    vrc_pkg::vrc_mul_req_t mul_req;
    logic [PW-1:0]         prod_reg;

    vrc_mul u_mul (
        .aclk     (aclk),
        .req      (mul_req),
        .prod_reg (prod_reg)
    );

    // Round a Q.32 product to Q.16, half up
    function automatic logic [18:0] rnd16(input logic [PW-1:0] v);
        logic [PW-1:0] s;
        s = v + PW'(32768);
        return s[34:16];
    endfunction

    // Add with saturation at the 17-bit maximum
    function automatic logic [16:0] add_sat(input logic [16:0] s, input logic [18:0] c);
        logic [19:0] t;
        t = 20'(s) + 20'(c);
        return (t > 20'(vrc_pkg::SUM_MAX)) ? vrc_pkg::SUM_MAX : t[16:0];
    endfunction

    function automatic logic [15:0] out_sat(input logic [16:0] s);
        return s[16] ? vrc_pkg::OUT_MAX : s[15:0];
    endfunction

    logic          s_acc;
    logic          upd_stall;
    logic [IW-1:0] idx_lo, idx_hi;
    logic [LW-1:0] lerp_sum;
    logic [EW-1:0] lerp;
    logic [TIW-1:0] ti_wide;
    logic [18:0]   t_rnd;
    logic [16:0]   t_new;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign upd_stall = (state_reg == ST_UPD) && last_reg && m_valid_reg && !m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Table position: p = (x*DEPTH) >> 4, index = p >> 16, fraction = p[15:0]
    assign idx_lo = far_next ? '0 : prod_reg[20 +: IW];
    assign idx_hi = idx_lo + IW'(1);

    // Interpolated value, converted to Q1.16
    assign lerp_sum = LW'(prod_reg[EW+15:0]) + LW'(32768);
    assign lerp     = lerp_sum[EW+15:16];
    assign ti_wide  = ((TIW'(a_reg - lerp) + TIW'(vrc_pkg::FB_RND)) >> vrc_pkg::FB_DOWN)
                      << vrc_pkg::FB_UP;

    assign t_rnd = rnd16(prod_reg);
    assign t_new = (t_rnd > 19'(vrc_pkg::Q_ONE)) ? vrc_pkg::Q_ONE : t_rnd[16:0];

    // Operand select for the shared multiplier
    always_comb begin
        mul_req.en = !upd_stall;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (state_reg)
            ST_X: begin
                mul_req.a = MW'(density_reg);
                mul_req.b = MW'(distance_reg);
            end
            ST_P: begin
                mul_req.a = prod_reg[MW-1:0];
                mul_req.b = MW'(vrc_pkg::EXP_TABLE_DEPTH);
            end
            ST_FRAC: begin
                mul_req.a = MW'(diff_reg);
                mul_req.b = MW'(f_reg);
            end
            ST_W: begin
                mul_req.a = MW'(t_reg);
                mul_req.b = MW'(vrc_pkg::Q_ONE - ti_reg);
            end
            ST_R: begin
                mul_req.a = MW'(w_reg);
                mul_req.b = MW'(red_reg);
            end
            ST_G: begin
                mul_req.a = MW'(w_reg);
                mul_req.b = MW'(green_reg);
            end
            ST_B: begin
                mul_req.a = MW'(w_reg);
                mul_req.b = MW'(blue_reg);
            end
            ST_T: begin
                mul_req.a = MW'(t_reg);
                mul_req.b = MW'(ti_reg);
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    // Sequencer and datapath updates
    always_comb begin
        state_next   = state_reg;
        a_next       = a_reg;
        diff_next    = diff_reg;
        f_next       = f_reg;
        far_next     = far_reg;
        ti_next      = ti_reg;
        w_next       = w_reg;
        t_next       = t_reg;
        sum_r_next   = sum_r_reg;
        sum_g_next   = sum_g_reg;
        sum_b_next   = sum_b_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        // Drop the pixel once the consumer takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (state_reg == ST_LERP) begin
            far_next = (prod_reg[PW-1:20] >= (PW-20)'(vrc_pkg::EXP_TABLE_DEPTH));
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_X;
                end
            end
            ST_X: state_next = ST_P;
            ST_P: state_next = ST_LERP;
            ST_LERP: begin
                a_next     = vrc_pkg::EXP_TAB[idx_lo];
                diff_next  = vrc_pkg::EXP_TAB[idx_lo] - vrc_pkg::EXP_TAB[idx_hi];
                f_next     = prod_reg[19:4];
                state_next = ST_FRAC;
            end
            ST_FRAC: state_next = ST_TI;
            ST_TI: begin
                if (far_reg) begin
                    ti_next = '0;
                end else if (ti_wide > TIW'(vrc_pkg::Q_ONE)) begin
                    ti_next = vrc_pkg::Q_ONE;
                end else begin
                    ti_next = ti_wide[16:0];
                end
                state_next = ST_W;
            end
            ST_W: state_next = ST_WR;
            ST_WR: begin
                w_next     = t_rnd[16:0];
                state_next = ST_R;
            end
            ST_R: state_next = ST_G;
            ST_G: begin
                sum_r_next = add_sat(sum_r_reg, rnd16(prod_reg));
                state_next = ST_B;
            end
            ST_B: begin
                sum_g_next = add_sat(sum_g_reg, rnd16(prod_reg));
                state_next = ST_T;
            end
            ST_T: begin
                sum_b_next = add_sat(sum_b_reg, rnd16(prod_reg));
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (!upd_stall) begin
                    state_next = ST_IDLE;
                    if (last_reg) begin
                        // Emit the pixel and restart the ray
                        m_data_next  = {out_sat(sum_b_reg), out_sat(sum_g_reg),
                                        out_sat(sum_r_reg), ray_reg};
                        m_valid_next = 1'b1;
                        t_next       = vrc_pkg::Q_ONE;
                        sum_r_next   = '0;
                        sum_g_next   = '0;
                        sum_b_next   = '0;
                    end else begin
                        t_next = t_new;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            t_reg       <= vrc_pkg::Q_ONE;
            sum_r_reg   <= '0;
            sum_g_reg   <= '0;
            sum_b_reg   <= '0;
            m_valid_reg <= 1'b0;
            far_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            t_reg       <= t_next;
            sum_r_reg   <= sum_r_next;
            sum_g_reg   <= sum_g_next;
            sum_b_reg   <= sum_b_next;
            m_valid_reg <= m_valid_next;
            far_reg     <= far_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            density_reg  <= s_tdata[15:0];
            distance_reg <= s_tdata[31:16];
            red_reg      <= s_tdata[47:32];
            green_reg    <= s_tdata[63:48];
            blue_reg     <= s_tdata[79:64];
            ray_reg      <= s_tdata[95:80];
            last_reg     <= s_tlast;
        end
        a_reg      <= a_next;
        diff_reg   <= diff_next;
        f_reg      <= f_next;
        ti_reg     <= ti_next;
        w_reg      <= w_next;
        m_data_reg <= m_data_next;
    end

    // A request occupies the sequencer for the following cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted while sequencer busy");

    // A pixel appears only out of the final step of a last sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_UPD && last_reg))
        else $error("pixel emitted outside final step");

    // Transmittance never exceeds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        t_reg <= vrc_pkg::Q_ONE)
        else $error("transmittance above one");

    // A ray restarts from T = 1 and empty red and blue sums after its pixel is loaded (green is not checked)
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg == ST_UPD && last_reg && !upd_stall) |->
            (t_reg == vrc_pkg::Q_ONE && sum_r_reg == '0 && sum_b_reg == '0))
        else $error("ray state not restarted");

endmodule

@@ rtl/vrc_mul.sv @@
module vrc_mul (
    input  logic                         aclk,
    input  vrc_pkg::vrc_mul_req_t        req,
    output logic [vrc_pkg::PROD_W-1:0]   prod_reg
);

    logic [vrc_pkg::PROD_W-1:0] prod_next;

    // Hold the last product while disabled
    always_comb begin
        prod_next = prod_reg;
        if (req.en) begin
            prod_next = vrc_pkg::PROD_W'(req.a) * vrc_pkg::PROD_W'(req.b);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule
